[src/swt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package swt_pkg;

   localparam int TABLE_DEPTH_DEF = 16;
   localparam int ID_BITS_DEF     = 8;
   localparam int TICK_BITS_DEF   = 32;

   localparam logic MODE_SLEEP = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   localparam logic [1:0] KIND_ACCEPTED = 2'd0;
   localparam logic [1:0] KIND_REJECTED = 2'd1;
   localparam logic [1:0] KIND_WOKEN    = 2'd2;

   // control of the queue head as seen by the execution side
   typedef struct packed {
      logic valid;
      logic mode;
   } head_ctl_type;

endpackage

`default_nettype wire

[src/swt_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module swt_front #(
   parameter int ID_BITS   = swt_pkg::ID_BITS_DEF,
   parameter int TICK_BITS = swt_pkg::TICK_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_mode,
   input  logic [ID_BITS-1:0]     req_thread_id,
   input  logic [TICK_BITS-1:0]   req_wake_tick,
   input  logic [TICK_BITS-1:0]   req_now_tick,
   output swt_pkg::head_ctl_type  head_ctl,
   output logic [ID_BITS-1:0]     head_id,
   output logic [TICK_BITS-1:0]   head_tick,
   input  logic                   head_pop
);
   import swt_pkg::*;

   // two-entry queue; each entry keeps only the tick its mode needs
   logic                 q_mode_ff [2];
   logic [ID_BITS-1:0]   q_id_ff   [2];
   logic [TICK_BITS-1:0] q_tick_ff [2];
   logic                 wp_ff, wp_in;
   logic                 rp_ff, rp_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic                 push;
   logic                 pop;

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign pop       = head_pop && (cnt_ff != 2'd0);

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mode_ff[wp_ff] <= req_mode;
         q_id_ff[wp_ff]   <= req_thread_id;
         q_tick_ff[wp_ff] <= (req_mode == MODE_TICK) ? req_now_tick : req_wake_tick;
      end
   end

   assign head_ctl.valid = (cnt_ff != 2'd0);
   assign head_ctl.mode  = q_mode_ff[rp_ff];
   assign head_id        = q_id_ff[rp_ff];
   assign head_tick      = q_tick_ff[rp_ff];

endmodule

`default_nettype wire

[src/swt_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module swt_back #(
   parameter int TABLE_DEPTH = swt_pkg::TABLE_DEPTH_DEF,
   parameter int ID_BITS     = swt_pkg::ID_BITS_DEF,
   parameter int TICK_BITS   = swt_pkg::TICK_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  swt_pkg::head_ctl_type  head_ctl,
   input  logic [ID_BITS-1:0]     head_id,
   input  logic [TICK_BITS-1:0]   head_tick,
   output logic                   head_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_kind,
   output logic [ID_BITS-1:0]     rsp_woken_id,
   output logic                   rsp_last
);
   import swt_pkg::*;

   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   localparam logic [CNT_W-1:0]     CNT_FULL      = CNT_W'(TABLE_DEPTH);
   localparam logic [TICK_BITS-1:0] TICK_ALL_ONES = '1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_EVAL = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [TICK_BITS-1:0] earliest_ff, earliest_in;
   logic [TICK_BITS-1:0] now_ff, now_in;
   logic [TICK_BITS-1:0] min_ff, min_in;
   logic [CNT_W-1:0]     rd_ff, rd_in;
   logic [CNT_W-1:0]     wr_ff, wr_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [ID_BITS-1:0]   pend_id_ff, pend_id_in;
   logic                 out_valid_ff, out_valid_in;
   logic [1:0]           out_kind_ff, out_kind_in;
   logic [ID_BITS-1:0]   out_id_ff, out_id_in;
   logic                 out_last_ff, out_last_in;

   logic [ID_BITS-1:0]   id_mem_ff   [TABLE_DEPTH];
   logic [TICK_BITS-1:0] tick_mem_ff [TABLE_DEPTH];
   logic [ID_BITS-1:0]   rd_id_ff;
   logic [TICK_BITS-1:0] rd_tick_ff;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [ID_BITS-1:0]   mem_wid;
   logic [TICK_BITS-1:0] mem_wtick;
   logic                 mem_re;
   logic [ADDR_W-1:0]    mem_raddr;
   logic                 out_free;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign mem_raddr = rd_ff[ADDR_W-1:0];

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      earliest_in   = earliest_ff;
      now_in        = now_ff;
      min_in        = min_ff;
      rd_in         = rd_ff;
      wr_in         = wr_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_kind_in   = out_kind_ff;
      out_id_in     = out_id_ff;
      out_last_in   = out_last_ff;
      head_pop      = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = wr_ff[ADDR_W-1:0];
      mem_wid       = rd_id_ff;
      mem_wtick     = rd_tick_ff;
      mem_re        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (head_ctl.valid) begin
               if (head_ctl.mode == MODE_SLEEP) begin
                  if (out_free) begin
                     head_pop     = 1'b1;
                     out_valid_in = 1'b1;
                     out_id_in    = head_id;
                     out_last_in  = 1'b1;
                     if (count_ff == CNT_FULL) begin
                        out_kind_in = KIND_REJECTED;
                     end else begin
                        out_kind_in = KIND_ACCEPTED;
                        mem_we      = 1'b1;
                        mem_waddr   = count_ff[ADDR_W-1:0];
                        mem_wid     = head_id;
                        mem_wtick   = head_tick;
                        count_in    = count_ff + CNT_W'(1);
                        if (head_tick < earliest_ff) begin
                           earliest_in = head_tick;
                        end
                     end
                  end
               end else begin
                  head_pop = 1'b1;
                  // drop ticks that come before the earliest wake
                  if (head_tick >= earliest_ff) begin
                     now_in   = head_tick;
                     min_in   = TICK_ALL_ONES;
                     rd_in    = '0;
                     wr_in    = '0;
                     state_in = ST_READ;
                  end
               end
            end
         end
         ST_READ: begin
            if (rd_ff == count_ff) begin
               state_in = ST_DONE;
            end else begin
               mem_re   = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (rd_tick_ff <= now_ff) begin
               // hold one woken id back so the final one can carry last
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_kind_in  = KIND_WOKEN;
                     out_id_in    = pend_id_ff;
                     out_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_id_in    = rd_id_ff;
                  rd_in         = rd_ff + CNT_W'(1);
                  state_in      = ST_READ;
               end
            end else begin
               // compact the survivor down to the write pointer
               mem_we = 1'b1;
               wr_in  = wr_ff + CNT_W'(1);
               rd_in  = rd_ff + CNT_W'(1);
               if (rd_tick_ff < min_ff) begin
                  min_in = rd_tick_ff;
               end
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (!pend_valid_ff || out_free) begin
               count_in    = wr_ff;
               earliest_in = min_ff;
               if (pend_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_kind_in  = KIND_WOKEN;
                  out_id_in    = pend_id_ff;
                  out_last_in  = 1'b1;
               end
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         earliest_ff   <= TICK_ALL_ONES;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         earliest_ff   <= earliest_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      min_ff      <= min_in;
      rd_ff       <= rd_in;
      wr_ff       <= wr_in;
      pend_id_ff  <= pend_id_in;
      out_kind_ff <= out_kind_in;
      out_id_ff   <= out_id_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         id_mem_ff[mem_waddr]   <= mem_wid;
         tick_mem_ff[mem_waddr] <= mem_wtick;
      end
      if (mem_re) begin
         rd_id_ff   <= id_mem_ff[mem_raddr];
         rd_tick_ff <= tick_mem_ff[mem_raddr];
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_kind     = out_kind_ff;
   assign rsp_woken_id = out_id_ff;
   assign rsp_last     = out_last_ff;

endmodule

`default_nettype wire

[src/sleep_wakeup_table.sv]
// Sleep table with wakeup timer.
// Request channel (req_*): req_mode 0 puts req_thread_id to sleep until
// req_wake_tick; req_mode 1 presents the current tick in req_now_tick.
// Response channel (rsp_*): one transfer per sleep request (accepted, or
// rejected when the table is full), and one woken transfer per thread due on
// a tick, oldest first, rsp_last set on the final one. A tick below the
// earliest wake tick, or one that finds nothing due, gives no transfer.
// Requests pass a two-entry queue to an execution sequencer, so new requests
// are taken while a response waits. A sleep request's response is registered
// once the sequencer takes it from the queue. A tick walks the table through
// a single-port entry memory, reading and then evaluating each stored entry,
// and stalls when a woken id must be sent while a response still waits.
// Reset empties the table, sets the earliest wake tick to all ones and drops
// queued requests. When rsp_ready is low the sequencer stalls whenever it
// must send one while another waits; the queue can then fill and drop req_ready.
`timescale 1ns / 1ps
`default_nettype none

module sleep_wakeup_table #(
   parameter int TABLE_DEPTH = swt_pkg::TABLE_DEPTH_DEF,
   parameter int ID_BITS     = swt_pkg::ID_BITS_DEF,
   parameter int TICK_BITS   = swt_pkg::TICK_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_mode,
   input  logic [ID_BITS-1:0]   req_thread_id,
   input  logic [TICK_BITS-1:0] req_wake_tick,
   input  logic [TICK_BITS-1:0] req_now_tick,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_kind,
   output logic [ID_BITS-1:0]   rsp_woken_id,
   output logic                 rsp_last
);
   import swt_pkg::*;

   head_ctl_type         head_ctl;
   logic [ID_BITS-1:0]   head_id;
   logic [TICK_BITS-1:0] head_tick;
   logic                 head_pop;

   swt_front #(
      .ID_BITS   (ID_BITS),
      .TICK_BITS (TICK_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_thread_id (req_thread_id),
      .req_wake_tick (req_wake_tick),
      .req_now_tick  (req_now_tick),
      .head_ctl      (head_ctl),
      .head_id       (head_id),
      .head_tick     (head_tick),
      .head_pop      (head_pop)
   );

   swt_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ID_BITS     (ID_BITS),
      .TICK_BITS   (TICK_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_ctl     (head_ctl),
      .head_id      (head_id),
      .head_tick    (head_tick),
      .head_pop     (head_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .rsp_woken_id (rsp_woken_id),
      .rsp_last     (rsp_last)
   );

`ifndef SYNTHESIS
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_ACCEPTED || rsp_kind == KIND_REJECTED ||
                     rsp_kind == KIND_WOKEN))
      else $error("response kind out of range");

   a_sleep_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_WOKEN) |-> rsp_last)
      else $error("sleep response without last");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");
`endif

endmodule

`default_nettype wire
